// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers used by the table unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SKV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SKV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/skv_pkg.sv =====
// ----------------------------------------------------------------------------
// skv_pkg
// commands, status codes, sequencer states and default sizes of the sorted
// key/value table
// ----------------------------------------------------------------------------
package skv_pkg;

   localparam int DefaultCapacity   = 64;
   localparam int DefaultKeyWidth   = 32;
   localparam int DefaultValueWidth = 32;

   localparam int CmdWidth    = 2;
   localparam int KeyWidth    = 32;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 7;

   typedef enum logic [CmdWidth-1:0] {
      CMD_INSERT = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SEARCH  = 7'b0000010,
      ST_COMPARE = 7'b0000100,
      ST_CHECK   = 7'b0001000,
      ST_SHIFT   = 7'b0010000,
      ST_WRITE   = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

endpackage

// ===== design/sorted_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit
// sorted key/value table with binary search, insert, erase, look up, clear
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY pairs in ascending unsigned key order in two
// single-port-read stores, and works one request word at a time: req_stall is
// high from acceptance until the result word is loaded into the response
// register. With n entries held, the binary search runs at most
// ceil(log2(n+1)) steps, each a registered store read, then a compare, and
// then probes the found position with a read and a check. Look up and every
// rejected request then finish. Insert moves the entries from the position
// on up by one and erase moves the entries above it down, one entry per cycle
// through the read and write ports of the stores; after the moves erase
// drains the last write and settles, insert drains, settles and writes the
// new pair, and both then finish. Clear empties the table at acceptance and
// goes straight to finish. A stalled response register holds the finish
// state until it frees. The stores are not cleared after reset; the probe may
// read the position at the entry count, but that read never counts as a hit.
module sorted_key_value_table_unit #(
   parameter int CAPACITY    = skv_pkg::DefaultCapacity,
   parameter int KEY_WIDTH   = skv_pkg::DefaultKeyWidth,
   parameter int VALUE_WIDTH = skv_pkg::DefaultValueWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [skv_pkg::CmdWidth-1:0]     req_cmd,
   input  logic [skv_pkg::KeyWidth-1:0]     req_key,
   input  logic [skv_pkg::ValueWidth-1:0]   req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [skv_pkg::StatusWidth-1:0]  rsp_status,
   output logic [skv_pkg::ValueWidth-1:0]   rsp_read_value,
   output logic [skv_pkg::CountWidth-1:0]   rsp_entry_count
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // stores
   logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
   logic [KEY_WIDTH-1:0]   rkey_ff;
   logic [VALUE_WIDTH-1:0] rval_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [KEY_WIDTH-1:0]   wr_key;
   logic [VALUE_WIDTH-1:0] wr_val;

   // control
   skv_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff, pend_in;

   // payload
   skv_pkg::cmd_type       cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CW-1:0]          lo_ff, lo_in;
   logic [CW-1:0]          hi_ff, hi_in;
   logic [CW-1:0]          mid_ff, mid_in;
   logic [CW-1:0]          cur_ff, cur_in;
   logic [AW-1:0]          dst_ff, dst_in;
   skv_pkg::status_type    status_ff, status_in;
   logic [VALUE_WIDTH-1:0] found_ff, found_in;
   logic [skv_pkg::StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [skv_pkg::ValueWidth-1:0]  rsp_value_ff, rsp_value_in;
   logic [skv_pkg::CountWidth-1:0]  rsp_count_ff, rsp_count_in;

   logic [63:0]   key_wide, value_wide, found_wide, count_wide;
   logic [CW-1:0] mid_calc;
   logic          hit;
   logic          more;
   logic [CW-1:0] src;
   logic          accept;

   // assertion helpers
   logic          fill_step_ok;
   logic          in_finish;
   logic          in_write;
   logic          rsp_load;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != skv_pkg::ST_IDLE);
   assign key_wide   = {32'b0, req_key};
   assign value_wide = {32'b0, req_value};
   assign found_wide = 64'(found_ff);
   assign count_wide = 64'(fill_ff);
   assign mid_calc   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hit        = (lo_ff < fill_ff) && (rkey_ff == key_ff);

   // next move of the shift: up for insert, down for erase
   always_comb begin
      if (cmd_ff == skv_pkg::CMD_INSERT) begin
         more = (cur_ff > lo_ff);
         src  = cur_ff - 1'b1;
      end else begin
         more = ((cur_ff + 1'b1) < fill_ff);
         src  = cur_ff + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cur_in        = cur_ff;
      dst_in        = dst_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = lo_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_key        = rkey_ff;
      wr_val        = rval_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         skv_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = skv_pkg::cmd_type'(req_cmd);
               key_in    = key_wide[KEY_WIDTH-1:0];
               value_in  = value_wide[VALUE_WIDTH-1:0];
               lo_in     = '0;
               hi_in     = fill_ff;
               status_in = skv_pkg::STATUS_OK;
               found_in  = '0;
               pend_in   = 1'b0;
               if (skv_pkg::cmd_type'(req_cmd) == skv_pkg::CMD_CLEAR) begin
                  fill_in  = '0;
                  state_in = skv_pkg::ST_FINISH;
               end else begin
                  state_in = skv_pkg::ST_SEARCH;
               end
            end
         end
         skv_pkg::ST_SEARCH: begin
            rd_en = 1'b1;
            if (lo_ff < hi_ff) begin
               rd_addr  = mid_calc[AW-1:0];
               mid_in   = mid_calc;
               state_in = skv_pkg::ST_COMPARE;
            end else begin
               // probe the lower bound position
               rd_addr  = lo_ff[AW-1:0];
               state_in = skv_pkg::ST_CHECK;
            end
         end
         skv_pkg::ST_COMPARE: begin
            if (rkey_ff < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = skv_pkg::ST_SEARCH;
         end
         skv_pkg::ST_CHECK: begin
            state_in = skv_pkg::ST_FINISH;
            case (cmd_ff)
               skv_pkg::CMD_INSERT: begin
                  if (hit) begin
                     status_in = skv_pkg::STATUS_DUPLICATE;
                  end else if (fill_ff == CW'(CAPACITY)) begin
                     status_in = skv_pkg::STATUS_FULL;
                  end else begin
                     cur_in   = fill_ff;
                     state_in = skv_pkg::ST_SHIFT;
                  end
               end
               skv_pkg::CMD_ERASE: begin
                  if (hit) begin
                     cur_in   = lo_ff;
                     state_in = skv_pkg::ST_SHIFT;
                  end else begin
                     status_in = skv_pkg::STATUS_NOT_FOUND;
                  end
               end
               skv_pkg::CMD_LOOKUP: begin
                  if (hit) begin
                     found_in = rval_ff;
                  end else begin
                     status_in = skv_pkg::STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  status_in = skv_pkg::STATUS_OK;
               end
            endcase
         end
         skv_pkg::ST_SHIFT: begin
            // write back the entry read last cycle while reading the next one
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (more) begin
               rd_en   = 1'b1;
               rd_addr = src[AW-1:0];
               dst_in  = cur_ff[AW-1:0];
               cur_in  = src;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (cmd_ff == skv_pkg::CMD_INSERT) begin
                     state_in = skv_pkg::ST_WRITE;
                  end else begin
                     fill_in  = fill_ff - 1'b1;
                     state_in = skv_pkg::ST_FINISH;
                  end
               end
            end
         end
         skv_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_key   = key_ff;
            wr_val   = value_ff;
            fill_in  = fill_ff + 1'b1;
            state_in = skv_pkg::ST_FINISH;
         end
         skv_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = found_wide[skv_pkg::ValueWidth-1:0];
               rsp_count_in  = count_wide[skv_pkg::CountWidth-1:0];
               state_in      = skv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skv_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      cur_ff        <= cur_in;
      dst_ff        <= dst_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rkey_ff <= key_mem[rd_addr];
         rval_ff <= val_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // entry count moves by one, or drops to zero on clear
   assign fill_step_ok = (fill_in == fill_ff) || (fill_in == fill_ff + 1'b1) ||
                         (fill_in == fill_ff - 1'b1) || (fill_in == '0);
   assign in_finish    = (state_ff == skv_pkg::ST_FINISH);
   assign in_write     = (state_ff == skv_pkg::ST_SHIFT) || (state_ff == skv_pkg::ST_WRITE);
   assign rsp_load     = rsp_valid_in && !rsp_valid_ff;

   `SKV_ASSERT(a_fill_bound, clock, reset, fill_ff <= CW'(CAPACITY), "fill count above capacity")
   `SKV_ASSERT(a_busy_after_accept, clock, reset, accept |=> req_stall, "not busy after accept")
   `SKV_ASSERT(a_fill_step, clock, reset, fill_step_ok, "fill count jumped")
   `SKV_ASSERT(a_write_states, clock, reset, wr_en |-> in_write, "store write out of place")
   `SKV_ASSERT(a_rsp_from_finish, clock, reset, rsp_load |-> in_finish, "word not from finish")

endmodule
